// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/lfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lfr_pkg
// Widths, request codes and controller/datapath link types for the LRU
// frame replacer.
// ----------------------------------------------------------------------------
package lfr_pkg;

	localparam int FRAMES  = 64;
	localparam int IDX_W   = $clog2(FRAMES);
	localparam int LEN_W   = $clog2(FRAMES + 1);
	localparam int REQ_W   = 2;
	localparam int FID_W   = 6;
	localparam int COUNT_W = 7;

	// request codes
	localparam logic [REQ_W-1:0] REQ_VICTIM = REQ_W'(0);
	localparam logic [REQ_W-1:0] REQ_PIN    = REQ_W'(1);
	localparam logic [REQ_W-1:0] REQ_UNPIN  = REQ_W'(2);

	// controller to datapath
	typedef struct packed {
		logic load;   // capture the incoming item
		logic search; // locate the frame in the list
		logic apply;  // update list and write the result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_pin; // incoming item needs a search pass
	} status_t;

endpackage

// ===== rtl/lfr_req_if.sv =====
// ----------------------------------------------------------------------------
// lfr_req_if
// Request channel: valid/ready handshake with request code and frame number.
// ----------------------------------------------------------------------------
interface lfr_req_if;
	import lfr_pkg::*;

	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [FID_W-1:0] frame_num;

	modport source (output valid, output req_type, output frame_num, input ready);
	modport sink   (input valid, input req_type, input frame_num, output ready);

endinterface

// ===== rtl/lfr_res_if.sv =====
// ----------------------------------------------------------------------------
// lfr_res_if
// Result channel: valid/ready handshake with victim info and list length.
// ----------------------------------------------------------------------------
interface lfr_res_if;
	import lfr_pkg::*;

	logic               valid;
	logic               ready;
	logic               victim_found;
	logic [FID_W-1:0]   victim_frame;
	logic [COUNT_W-1:0] evictable_count;

	modport source (output valid, output victim_found, output victim_frame,
		output evictable_count, input ready);
	modport sink   (input valid, input victim_found, input victim_frame,
		input evictable_count, output ready);

endinterface

// ===== rtl/lfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfr_ctrl
// Sequencer: accept, optional search pass, apply into the result register.
// ----------------------------------------------------------------------------
module lfr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  lfr_pkg::status_t status,
	output lfr_pkg::cmd_t    cmd
);
	import lfr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_APPLY
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// handshake and commands
	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.load   = in_valid && in_ready;
	assign cmd.search = (state_q == ST_SEARCH);
	assign cmd.apply  = (state_q == ST_APPLY) && (!out_valid_q || out_ready);

	// state and result-valid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load)
						state_q <= status.is_pin ? ST_SEARCH : ST_APPLY;
				end
				ST_SEARCH: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (cmd.apply) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/lfr_dp.sv =====
// ----------------------------------------------------------------------------
// lfr_dp
// Shifting list of frame numbers, per-frame presence marks, list length
// and the result register.
// ----------------------------------------------------------------------------
module lfr_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lfr_pkg::cmd_t               cmd,
	output lfr_pkg::status_t            status,
	input  logic [lfr_pkg::REQ_W-1:0]   in_req_type,
	input  logic [lfr_pkg::FID_W-1:0]   in_frame_num,
	output logic                        res_victim_found,
	output logic [lfr_pkg::FID_W-1:0]   res_victim_frame,
	output logic [lfr_pkg::COUNT_W-1:0] res_evictable_count
);
	import lfr_pkg::*;

	// captured item
	logic [REQ_W-1:0] req_q;
	logic [FID_W-1:0] fid_q;

	// list row (entry 0 least recent), marks, length
	logic [FID_W-1:0]  order_q [FRAMES];
	logic [FRAMES-1:0] mark_q;
	logic [LEN_W-1:0]  len_q;

	// shift mask from the search pass
	logic [FRAMES-1:0] shift_q;

	// result register
	logic               found_q;
	logic [FID_W-1:0]   vframe_q;
	logic [COUNT_W-1:0] count_q;

	logic [FRAMES-1:0] hit;
	logic [FRAMES-1:0] shift_n;
	logic [FRAMES-1:0] shift_sel;
	logic [IDX_W-1:0]  fid_idx;
	logic [IDX_W-1:0]  head_idx;
	logic [IDX_W-1:0]  tail_idx;
	logic              fid_ok;
	logic              len_nz;
	logic              pin_hit;
	logic              do_victim;
	logic              do_pin;
	logic              do_add;
	logic              do_shift;
	logic [LEN_W-1:0]  len_next;

	assign status.is_pin = (in_req_type == REQ_PIN);

	// capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_req_type;
			fid_q <= in_frame_num;
		end
	end

	// search: match per entry, then mark every entry at or above the match
	always_comb begin
		for (int i = 0; i < FRAMES; i++)
			hit[i] = (order_q[i] == fid_q) && (LEN_W'(i) < len_q);
		for (int i = 0; i < FRAMES; i++)
			shift_n[i] = |(hit & ({FRAMES{1'b1}} >> (FRAMES - 1 - i)));
	end

	always_ff @(posedge clk) begin
		if (cmd.search)
			shift_q <= shift_n;
	end

	// decode the update
	assign fid_idx  = IDX_W'(fid_q);
	assign head_idx = IDX_W'(order_q[0]);
	assign tail_idx = len_q[IDX_W-1:0];
	assign fid_ok   = (int'(fid_q) < FRAMES);
	assign len_nz   = (len_q != '0);
	assign pin_hit  = fid_ok && mark_q[fid_idx];

	always_comb begin
		do_victim = 1'b0;
		do_pin    = 1'b0;
		do_add    = 1'b0;
		shift_sel = shift_q;
		unique case (req_q)
			REQ_VICTIM: begin
				do_victim = len_nz;
				shift_sel = {FRAMES{1'b1}};
			end
			REQ_PIN: begin
				do_pin = pin_hit;
			end
			REQ_UNPIN: begin
				do_add = fid_ok && !mark_q[fid_idx] && (len_q < LEN_W'(FRAMES));
			end
			default: begin
			end
		endcase
		do_shift = do_victim || do_pin;
		if (do_shift)
			len_next = len_q - LEN_W'(1);
		else if (do_add)
			len_next = len_q + LEN_W'(1);
		else
			len_next = len_q;
	end

	// list row: shift down over the removed entry, append at the tail
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			if (do_shift) begin
				for (int i = 0; i < FRAMES - 1; i++)
					if (shift_sel[i])
						order_q[i] <= order_q[i+1];
			end
			if (do_add)
				order_q[tail_idx] <= fid_q;
		end
	end

	// marks and length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= '0;
			len_q  <= '0;
		end else if (cmd.apply) begin
			if (do_victim)
				mark_q[head_idx] <= 1'b0;
			if (do_pin)
				mark_q[fid_idx] <= 1'b0;
			if (do_add)
				mark_q[fid_idx] <= 1'b1;
			len_q <= len_next;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			found_q  <= do_victim;
			vframe_q <= do_victim ? order_q[0] : '0;
			count_q  <= COUNT_W'(len_next);
		end
	end

	assign res_victim_found    = found_q;
	assign res_victim_frame    = vframe_q;
	assign res_evictable_count = count_q;

endmodule

// ===== rtl/lru_frame_replacer_top.sv =====
// ----------------------------------------------------------------------------
// lru_frame_replacer_top: LRU replacement list over a shifting row of frames
// Sequence: accept, then apply; a pin request passes a search state between.
// One item is in flight at a time; the next is accepted after the last apply,
// and a result that is not taken holds the next item back.
// Reset clears marks, length and sequencer; the frame row is left unwritten.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_frame_replacer_top (
	input logic       clk,
	input logic       arst_n,
	lfr_req_if.sink   req,
	lfr_res_if.source res
);
	import lfr_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer
	lfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// list datapath
	lfr_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.in_req_type         (req.req_type),
		.in_frame_num        (req.frame_num),
		.res_victim_found    (res.victim_found),
		.res_victim_frame    (res.victim_frame),
		.res_evictable_count (res.evictable_count)
	);

	// one item in flight at a time
	`ASSERT_CLK(a_busy_after_accept, clk, arst_n, (req.valid && req.ready) |=> !req.ready, "accepted while busy")
	// the result register is never overwritten while still held
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.apply && res.valid && !res.ready, "result overwritten")
	// an update always raises the result
	`ASSERT_CLK(a_apply_valid, clk, arst_n, cmd.apply |=> res.valid, "result not raised")
	// no victim means a zero frame field
	`ASSERT_CLK(a_zero_frame, clk, arst_n, (res.valid && !res.victim_found) |-> (res.victim_frame == '0), "stray victim frame")

endmodule
